>>> rtl/mis_pkg.sv
// Shared constants and types for the merge insertion sorter.
// Used by mis_cell and merge_insertion_sorter; depends on nothing else.
package mis_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int DATA_W = 32;
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0] count_t;

	// Command broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic  ins;
		logic  shift;
		data_t value;
	} mis_ctrl_t;

endpackage

>>> rtl/mis_cell.sv
// One storage cell of the insertion chain: holds one value and its valid bit.
// Depends on mis_pkg for the data and command types.
module mis_cell
	import mis_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  mis_ctrl_t ctrl,
	input  data_t     left_value,
	input  logic      left_valid,
	input  logic      left_after,
	input  data_t     right_value,
	input  logic      right_valid,
	output data_t     cell_value,
	output logic      cell_valid,
	output logic      cell_after
);

	data_t value_q;
	logic  valid_q;

	// The new value belongs at or before this cell when the cell is empty or
	// holds a strictly greater value, so equal values keep arrival order.
	assign cell_after = !valid_q || (value_q > ctrl.value);
	assign cell_value = value_q;
	assign cell_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins) begin
			valid_q <= valid_q || left_valid;
		end else if (ctrl.shift) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (cell_after) begin
				value_q <= left_after ? left_value : ctrl.value;
			end
		end else if (ctrl.shift) begin
			value_q <= right_value;
		end
	end

endmodule

>>> rtl/merge_insertion_sorter.sv
// Top level of the merge insertion sorter: a chain of mis_cell instances and
// the request and drain control. Depends on mis_pkg and mis_cell.
//
// Usage: a request is taken at a rising edge where start is high and busy is
// low; value and last_in are sampled there. Each value is placed into an
// ascending chain of MAX_ITEMS cells in the same cycle, so one request is
// taken per clock while a set is being loaded. Values beyond MAX_ITEMS are
// dropped, and the overflow flag then stays set until the set has left.
// The request with last_in high closes the set. From the next cycle on, busy
// is high and the set leaves in ascending order, one result per cycle, each
// marked by strobe for exactly one cycle. The first result appears in the
// cycle after the closing request, and the chain shifts toward cell zero once
// per result. last_out marks the largest value.
// A new request is taken in the cycle after the final result.
// The receiver cannot stall; results must be taken when strobe is high.
// Reset clears the valid bits, the count and the overflow flag at once; the
// block is ready in the first cycle after reset.
module merge_insertion_sorter
	import mis_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  data_t value,
	input  logic  last_in,
	output logic  strobe,
	output data_t sorted_value,
	output logic  last_out,
	output logic  overflow
);

	logic      drain_q;
	count_t    count_q;
	logic      dropped_q;
	logic      accept;
	logic      full;
	mis_ctrl_t ctrl;

	data_t chain_value [MAX_ITEMS+1];
	logic  chain_valid [MAX_ITEMS+1];
	logic  chain_after [MAX_ITEMS+1];

	assign accept = start && !drain_q;
	assign full = (count_q == count_t'(MAX_ITEMS));

	assign ctrl.ins = accept && !full;
	assign ctrl.shift = drain_q;
	assign ctrl.value = value;

	// Left boundary of cell zero: never shifts in, always counts as filled.
	assign chain_value[0] = '0;
	assign chain_valid[0] = 1'b1;
	assign chain_after[0] = 1'b0;

	genvar g;
	generate
		for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
			data_t right_value;
			logic  right_valid;
			logic  cell_after;

			if (g == MAX_ITEMS - 1) begin : g_end
				assign right_value = '0;
				assign right_valid = 1'b0;
			end else begin : g_mid
				assign right_value = chain_value[g+2];
				assign right_valid = chain_valid[g+2];
			end

			mis_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.left_value  (chain_value[g]),
				.left_valid  (chain_valid[g]),
				.left_after  (chain_after[g]),
				.right_value (right_value),
				.right_valid (right_valid),
				.cell_value  (chain_value[g+1]),
				.cell_valid  (chain_valid[g+1]),
				.cell_after  (cell_after)
			);

			assign chain_after[g+1] = cell_after;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q   <= 1'b0;
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (drain_q) begin
			count_q <= count_q - count_t'(1);
			if (count_q == count_t'(1)) begin
				drain_q   <= 1'b0;
				dropped_q <= 1'b0;
			end
		end else if (accept) begin
			if (full) begin
				dropped_q <= 1'b1;
			end else begin
				count_q <= count_q + count_t'(1);
			end
			if (last_in) begin
				drain_q <= 1'b1;
			end
		end
	end

	assign busy = drain_q;
	assign strobe = drain_q;
	assign sorted_value = chain_value[1];
	assign last_out = drain_q && (count_q == count_t'(1));
	assign overflow = dropped_q;

endmodule
